>>> src/ilmd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the instruction length and mode decoder.
package ilmd_pkg;

   localparam int MAX_BYTES  = 5;
   localparam int CountWidth = $clog2(MAX_BYTES + 1);
   localparam int IndexWidth = $clog2(MAX_BYTES);

   localparam logic [7:0]  PREFIX_PAGE2      = 8'h10;
   localparam logic [7:0]  PREFIX_PAGE3      = 8'h11;
   localparam logic [7:0]  OP_BRANCH_SUB_REL = 8'h8d;
   localparam logic [7:0]  EXT_INDIRECT_MASK = 8'h9f;
   localparam logic [7:0]  INDEXED_MASK      = 8'h8f;
   localparam logic [7:0]  INDIRECT_FLAG     = 8'h10;
   localparam logic [15:0] PAGE_MASK         = 16'hfff0;

   typedef enum logic [4:0] {
      MODE_INVALID,
      MODE_INHERENT,
      MODE_DIRECT,
      MODE_EXTENDED,
      MODE_REL8,
      MODE_REL16,
      MODE_IMM8,
      MODE_IMM16,
      MODE_IDX_ZERO,
      MODE_IDX_ZERO_IND,
      MODE_IDX_OFF5,
      MODE_IDX_OFF8,
      MODE_IDX_OFF8_IND,
      MODE_IDX_OFF16,
      MODE_IDX_OFF16_IND,
      MODE_IDX_ACC,
      MODE_IDX_ACC_IND,
      MODE_IDX_INC1,
      MODE_IDX_INC2,
      MODE_IDX_INC2_IND,
      MODE_IDX_DEC1,
      MODE_IDX_DEC2,
      MODE_IDX_DEC2_IND,
      MODE_PCR8,
      MODE_PCR8_IND,
      MODE_PCR16,
      MODE_PCR16_IND,
      MODE_EXT_IND,
      MODE_REG_XFER,
      MODE_STACK
   } mode_type;

   typedef struct packed {
      logic [7:0]  fetch_byte;
      logic [15:0] byte_address;
      logic        first_of_instruction;
   } req_type;

   typedef struct packed {
      logic [4:0]  mode_code;
      logic [2:0]  total_length;
      logic [15:0] target_address;
      logic        target_valid;
      logic        invalid_opcode;
   } rsp_type;

   typedef struct packed {
      mode_type mode;
      logic     more;
   } decode_type;

   function automatic mode_type indexed_mode(input logic [7:0] pb);
      mode_type m;
      logic     ind;
      m   = MODE_INVALID;
      ind = (pb & INDIRECT_FLAG) != 8'h00;
      if ((pb & EXT_INDIRECT_MASK) == EXT_INDIRECT_MASK) begin
         m = MODE_EXT_IND;
      end else if (!pb[7]) begin
         m = MODE_IDX_OFF5;
      end else begin
         case (pb & INDEXED_MASK)
            8'h84:               m = ind ? MODE_IDX_ZERO_IND  : MODE_IDX_ZERO;
            8'h88:               m = ind ? MODE_IDX_OFF8_IND  : MODE_IDX_OFF8;
            8'h89:               m = ind ? MODE_IDX_OFF16_IND : MODE_IDX_OFF16;
            8'h85, 8'h86, 8'h8b: m = ind ? MODE_IDX_ACC_IND   : MODE_IDX_ACC;
            8'h80:               m = ind ? MODE_INVALID       : MODE_IDX_INC1;
            8'h81:               m = ind ? MODE_IDX_INC2_IND  : MODE_IDX_INC2;
            8'h82:               m = ind ? MODE_INVALID       : MODE_IDX_DEC1;
            8'h83:               m = ind ? MODE_IDX_DEC2_IND  : MODE_IDX_DEC2;
            8'h8c:               m = ind ? MODE_PCR8_IND      : MODE_PCR8;
            8'h8d:               m = ind ? MODE_PCR16_IND     : MODE_PCR16;
            default:             m = MODE_INVALID;
         endcase
      end
      return m;
   endfunction

   function automatic logic [1:0] extra_bytes(input mode_type m);
      logic [1:0] e;
      case (m)
         MODE_INVALID, MODE_INHERENT:                           e = 2'd0;
         MODE_EXTENDED, MODE_REL16, MODE_IMM16,
         MODE_IDX_OFF8, MODE_IDX_OFF8_IND,
         MODE_PCR8, MODE_PCR8_IND:                              e = 2'd2;
         MODE_IDX_OFF16, MODE_IDX_OFF16_IND,
         MODE_PCR16, MODE_PCR16_IND, MODE_EXT_IND:              e = 2'd3;
         default:                                               e = 2'd1;
      endcase
      return e;
   endfunction

endpackage

>>> src/instruction_length_mode_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the instruction length and addressing mode decoder.
//
// Fetch bytes enter on the req_ channel, one transaction per byte, with the bus
// address and a flag that marks the first byte of an instruction. A first byte
// drops any partly collected instruction. A byte without that flag while no
// instruction is open is dropped silently.
// One transaction leaves on the rsp_ channel when the last byte of an
// instruction arrives, or as soon as the bytes show an undecodable opcode.
// Throughput: one byte per cycle while the result register is not held by
// rsp_stall. Each byte passes an input register, a combinational decode against
// the held bytes, and the result register, which drives rsp_valid.
// When the receiver raises rsp_stall the result holds; the byte in the input
// register then waits and req_stall rises until the result is taken.
// Reset (synchronous) empties both registers and closes any open instruction.
module instruction_length_mode_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ilmd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ilmd_pkg::rsp_type rsp_payload
);
   import ilmd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    out_free;
   logic    advance;
   logic    accept;
   logic    res_valid;
   rsp_type res;

   ilmd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_data_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      accept       = req_valid && !req_stall;
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = (advance && res_valid) || (out_valid_ff && !out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

>>> src/ilmd_mode_decode.sv
`timescale 1ns / 1ps
// Addressing mode decode from the opcode, prefix and postbyte held so far.
module ilmd_mode_decode (
   input  logic [7:0]                        op,
   input  logic [7:0]                        b1,
   input  logic [7:0]                        b2,
   input  logic [ilmd_pkg::CountWidth-1:0]   seen,
   output ilmd_pkg::decode_type              dec
);
   import ilmd_pkg::*;

   logic [15:0] page;
   logic        need_post;

   always_comb begin
      dec.mode  = MODE_INVALID;
      dec.more  = 1'b0;
      need_post = 1'b0;
      page      = {op, b1} & PAGE_MASK;
      if (op == PREFIX_PAGE2 || op == PREFIX_PAGE3) begin
         if (seen < CountWidth'(2)) begin
            dec.more = 1'b1;
         end else begin
            case (page)
               16'h1020:                     dec.mode = MODE_REL16;
               16'h1030, 16'h1130:           dec.mode = MODE_INHERENT;
               16'h1080, 16'h1180, 16'h10c0: dec.mode = MODE_IMM16;
               16'h1090, 16'h1190, 16'h10d0: dec.mode = MODE_DIRECT;
               16'h10a0, 16'h11a0, 16'h10e0: begin
                  if (seen < CountWidth'(3)) dec.more = 1'b1;
                  else dec.mode = indexed_mode(b2);
               end
               16'h10b0, 16'h11b0, 16'h10f0: dec.mode = MODE_EXTENDED;
               default:                      dec.mode = MODE_INVALID;
            endcase
         end
      end else begin
         case (op[7:4])
            4'h0, 4'h9, 4'hd: dec.mode = MODE_DIRECT;
            4'h1: begin
               if (op inside {8'h12, 8'h13, 8'h19, 8'h1d}) dec.mode = MODE_INHERENT;
               else if (op inside {8'h16, 8'h17})         dec.mode = MODE_REL16;
               else if (op inside {8'h1a, 8'h1c})         dec.mode = MODE_IMM8;
               else if (op inside {8'h1e, 8'h1f})         dec.mode = MODE_REG_XFER;
               else                                       dec.mode = MODE_INVALID;
            end
            4'h2: dec.mode = MODE_REL8;
            4'h3: begin
               if (op inside {[8'h30:8'h33]})      need_post = 1'b1;
               else if (op inside {[8'h34:8'h37]}) dec.mode  = MODE_STACK;
               else if (op == 8'h38)               dec.mode  = MODE_INVALID;
               else                                dec.mode  = MODE_INHERENT;
            end
            4'h4, 4'h5:       dec.mode  = MODE_INHERENT;
            4'h6, 4'ha, 4'he: need_post = 1'b1;
            4'h7, 4'hb, 4'hf: dec.mode  = MODE_EXTENDED;
            default: begin
               if (op == OP_BRANCH_SUB_REL)             dec.mode = MODE_REL8;
               else if (op[3:0] inside {4'h3, 4'hc, 4'he}) dec.mode = MODE_IMM16;
               else                                     dec.mode = MODE_IMM8;
            end
         endcase
         if (need_post) begin
            if (seen < CountWidth'(2)) dec.more = 1'b1;
            else dec.mode = indexed_mode(b1);
         end
      end
   end

endmodule

>>> src/ilmd_core.sv
`timescale 1ns / 1ps
// Instruction byte store, decode state and result forming: one transaction per fire cycle.
module ilmd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  ilmd_pkg::req_type item,
   output logic              res_valid,
   output ilmd_pkg::rsp_type res
);
   import ilmd_pkg::*;

   logic [7:0]            store_ff [MAX_BYTES];
   logic [7:0]            store_in [MAX_BYTES];
   logic [7:0]            held     [MAX_BYTES];
   logic [CountWidth-1:0] seen_ff, seen_in;
   logic [CountWidth-1:0] needed_ff, needed_in;
   mode_type              mode_ff, mode_in;
   logic [15:0]           start_ff, start_in;
   logic                  coll_ff, coll_in;

   logic                  active;
   logic                  prefix;
   logic                  pcrel;
   logic                  short_off;
   logic                  has_target;
   logic [IndexWidth-1:0] off_idx;
   logic [IndexWidth-1:0] off_idx_lo;
   logic [15:0]           offset;
   decode_type            dec;

   ilmd_mode_decode u_mode_decode (
      .op   (held[0]),
      .b1   (held[1]),
      .b2   (held[2]),
      .seen (seen_in),
      .dec  (dec)
   );

   always_comb begin
      store_in  = store_ff;
      seen_in   = seen_ff;
      needed_in = needed_ff;
      mode_in   = mode_ff;
      start_in  = start_ff;
      coll_in   = coll_ff;
      active    = 1'b0;
      if (item.first_of_instruction) begin
         store_in[0] = item.fetch_byte;
         seen_in     = CountWidth'(1);
         needed_in   = '0;
         mode_in     = MODE_INVALID;
         start_in    = item.byte_address;
         coll_in     = 1'b1;
         active      = 1'b1;
      end else if (coll_ff) begin
         active = 1'b1;
         if (seen_ff < CountWidth'(MAX_BYTES)) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
               if (seen_ff == CountWidth'(k)) store_in[k] = item.fetch_byte;
            end
            seen_in = seen_ff + CountWidth'(1);
         end
      end
      for (int k = 0; k < MAX_BYTES; k++) begin
         held[k] = (CountWidth'(k) < seen_in) ? store_in[k] : 8'h00;
      end
      prefix = (held[0] == PREFIX_PAGE2) || (held[0] == PREFIX_PAGE3);

      res_valid = 1'b0;
      res       = '0;
      if (active && needed_in == '0) begin
         if (dec.mode == MODE_INVALID) begin
            if (!dec.more || seen_in >= CountWidth'(MAX_BYTES)) begin
               coll_in            = 1'b0;
               res_valid          = 1'b1;
               res.total_length   = seen_in[2:0];
               res.invalid_opcode = 1'b1;
            end
         end else begin
            mode_in   = dec.mode;
            needed_in = CountWidth'(1) + CountWidth'(extra_bytes(dec.mode))
                        + CountWidth'(prefix);
         end
      end

      pcrel      = (mode_in == MODE_PCR8) || (mode_in == MODE_PCR8_IND)
                   || (mode_in == MODE_PCR16) || (mode_in == MODE_PCR16_IND);
      short_off  = (mode_in == MODE_REL8) || (mode_in == MODE_PCR8)
                   || (mode_in == MODE_PCR8_IND);
      has_target = pcrel || (mode_in == MODE_REL8) || (mode_in == MODE_REL16);
      off_idx    = IndexWidth'(1) + IndexWidth'(prefix) + IndexWidth'(pcrel);
      off_idx_lo = off_idx + IndexWidth'(1);
      offset     = short_off ? {{8{held[off_idx][7]}}, held[off_idx]}
                             : {held[off_idx], held[off_idx_lo]};

      if (active && !res_valid && needed_in != '0 && seen_in == needed_in) begin
         coll_in            = 1'b0;
         res_valid          = 1'b1;
         res.mode_code      = mode_in;
         res.total_length   = needed_in[2:0];
         res.target_valid   = has_target;
         res.target_address = has_target ? start_in + offset : 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         needed_ff <= '0;
         mode_ff   <= MODE_INVALID;
         start_ff  <= '0;
         coll_ff   <= 1'b0;
      end else if (fire) begin
         seen_ff   <= seen_in;
         needed_ff <= needed_in;
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         coll_ff   <= coll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         store_ff <= store_in;
      end
   end

endmodule

>>> src/ilmd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the instruction length and addressing mode decoder.
module ilmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ilmd_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ilmd_pkg::rsp_type rsp_payload
);
   import ilmd_pkg::*;

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled response changed or dropped");

   property p_req_hold;
      @(posedge clock) disable iff (reset)
         req_valid && req_stall |=> req_valid && $stable(req_payload);
   endproperty
   a_req_hold: assert property (p_req_hold)
      else $error("stalled request changed or dropped");

   property p_invalid_shape;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_payload.invalid_opcode |->
            rsp_payload.mode_code == 5'(MODE_INVALID) && !rsp_payload.target_valid
            && rsp_payload.target_address == 16'h0000 && rsp_payload.total_length != 3'd0;
   endproperty
   a_invalid_shape: assert property (p_invalid_shape)
      else $error("invalid-opcode transaction carries mode or target");

   property p_valid_shape;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_payload.invalid_opcode |->
            rsp_payload.mode_code != 5'(MODE_INVALID) && rsp_payload.total_length != 3'd0
            && rsp_payload.total_length <= 3'd5
            && (rsp_payload.target_valid || rsp_payload.target_address == 16'h0000);
   endproperty
   a_valid_shape: assert property (p_valid_shape)
      else $error("decoded transaction has bad mode, length or target");

   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid && !req_stall;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("pipeline not empty after reset");

endmodule

bind instruction_length_mode_decoder_top ilmd_checker u_ilmd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
